// File: rtl/arlt_pkg.sv
// ----------------------------------------------------------------------------
// arlt_pkg
// Types, action codes, S-box tables and GF(2^8) helpers for the AES round
// layer transform.
// ----------------------------------------------------------------------------
package arlt_pkg;

	localparam int unsigned NB = 16;

	localparam logic [2:0] ACT_SUB_BYTES     = 3'd0;
	localparam logic [2:0] ACT_SHIFT_ROWS    = 3'd1;
	localparam logic [2:0] ACT_MIX_COLUMNS   = 3'd2;
	localparam logic [2:0] ACT_INV_SUB_BYTES = 3'd3;
	localparam logic [2:0] ACT_INV_SHIFT_ROWS = 3'd4;
	localparam logic [2:0] ACT_INV_MIX_COLUMNS = 3'd5;

	typedef struct packed {
		logic [2:0]  action;
		logic [63:0] state_hi;
		logic [63:0] state_lo;
	} req_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
	} rsp_t;

	// element 0 is the most significant byte, i.e. state byte 0
	typedef logic [0:NB-1][7:0] state_t;

	localparam logic [7:0] SBOX_FWD [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] SBOX_INV [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul2(input logic [7:0] a);
		gf_mul2 = xtime(a);
	endfunction

	function automatic logic [7:0] gf_mul3(input logic [7:0] a);
		gf_mul3 = xtime(a) ^ a;
	endfunction

	function automatic logic [7:0] gf_mul9(input logic [7:0] a);
		gf_mul9 = xtime(xtime(xtime(a))) ^ a;
	endfunction

	function automatic logic [7:0] gf_mul11(input logic [7:0] a);
		gf_mul11 = xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
	endfunction

	function automatic logic [7:0] gf_mul13(input logic [7:0] a);
		gf_mul13 = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
	endfunction

	function automatic logic [7:0] gf_mul14(input logic [7:0] a);
		gf_mul14 = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
	endfunction

endpackage

// File: rtl/arlt_sub.sv
// ----------------------------------------------------------------------------
// arlt_sub
// SubBytes / InvSubBytes layer: sixteen parallel S-box lookups.
// ----------------------------------------------------------------------------
module arlt_sub (
	input  logic             inv,
	input  arlt_pkg::state_t din,
	output arlt_pkg::state_t dout
);
	import arlt_pkg::*;

	always_comb begin
		for (int i = 0; i < NB; i++) begin
			dout[i] = inv ? SBOX_INV[din[i]] : SBOX_FWD[din[i]];
		end
	end

endmodule

// File: rtl/arlt_mix.sv
// ----------------------------------------------------------------------------
// arlt_mix
// MixColumns / InvMixColumns layer over GF(2^8), polynomial 0x11B.
// ----------------------------------------------------------------------------
module arlt_mix (
	input  logic             inv,
	input  arlt_pkg::state_t din,
	output arlt_pkg::state_t dout
);
	import arlt_pkg::*;

	always_comb begin
		logic [7:0] a0, a1, a2, a3;
		for (int c = 0; c < 4; c++) begin
			a0 = din[c];
			a1 = din[4 + c];
			a2 = din[8 + c];
			a3 = din[12 + c];
			if (inv) begin
				dout[c]      = gf_mul14(a0) ^ gf_mul11(a1) ^ gf_mul13(a2) ^ gf_mul9(a3);
				dout[4 + c]  = gf_mul9(a0)  ^ gf_mul14(a1) ^ gf_mul11(a2) ^ gf_mul13(a3);
				dout[8 + c]  = gf_mul13(a0) ^ gf_mul9(a1)  ^ gf_mul14(a2) ^ gf_mul11(a3);
				dout[12 + c] = gf_mul11(a0) ^ gf_mul13(a1) ^ gf_mul9(a2)  ^ gf_mul14(a3);
			end else begin
				dout[c]      = gf_mul2(a0) ^ gf_mul3(a1) ^ a2 ^ a3;
				dout[4 + c]  = a0 ^ gf_mul2(a1) ^ gf_mul3(a2) ^ a3;
				dout[8 + c]  = a0 ^ a1 ^ gf_mul2(a2) ^ gf_mul3(a3);
				dout[12 + c] = gf_mul3(a0) ^ a1 ^ a2 ^ gf_mul2(a3);
			end
		end
	end

endmodule

// File: rtl/aes_round_layer_transform_core.sv
// ----------------------------------------------------------------------------
// aes_round_layer_transform_core
// A request transferred into the input register takes one pass of S-box /
// shift / mix logic and is captured in the result register, which drives rsp.
// Throughput: one block per cycle while rsp_stall is low, set by the
// single-pass datapath.
// Reset: arst_n clears both valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
module aes_round_layer_transform_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  arlt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output arlt_pkg::rsp_t  rsp
);
	import arlt_pkg::*;

	logic   valid_s1;
	req_t   req_s1;
	logic   valid_s2;
	rsp_t   rsp_s2;
	logic   adv_s2;
	logic   load_s1;
	state_t st;
	state_t sub_out;
	state_t mix_out;
	state_t shf_out;
	state_t res;
	logic   inv_sub;
	logic   inv_mix;

	assign adv_s2    = ~(valid_s2 & rsp_stall);
	assign load_s1   = ~valid_s1 | adv_s2;
	assign req_stall = valid_s1 & ~adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && req_valid) begin
			req_s1 <= req;
		end
	end

	assign st      = {req_s1.state_hi, req_s1.state_lo};
	assign inv_sub = (req_s1.action == ACT_INV_SUB_BYTES);
	assign inv_mix = (req_s1.action == ACT_INV_MIX_COLUMNS);

	arlt_sub u_sub (
		.inv  (inv_sub),
		.din  (st),
		.dout (sub_out)
	);

	arlt_mix u_mix (
		.inv  (inv_mix),
		.din  (st),
		.dout (mix_out)
	);

	// row r rotates left by r, right by r for the inverse
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (req_s1.action == ACT_INV_SHIFT_ROWS) begin
					shf_out[r * 4 + c] = st[r * 4 + ((c + 4 - r) % 4)];
				end else begin
					shf_out[r * 4 + c] = st[r * 4 + ((c + r) % 4)];
				end
			end
		end
	end

	always_comb begin
		unique case (req_s1.action)
			ACT_SUB_BYTES, ACT_INV_SUB_BYTES:     res = sub_out;
			ACT_SHIFT_ROWS, ACT_INV_SHIFT_ROWS:   res = shf_out;
			ACT_MIX_COLUMNS, ACT_INV_MIX_COLUMNS: res = mix_out;
			default:                              res = st;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			rsp_s2 <= res;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule
